// File: rtl/sud_pkg.sv
`default_nettype none

package sud_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned DIST_W = 11;

   localparam logic [7:0] SIG_LEN_RESET = 8'd124;
   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [7:0] BYTE_ONE = 8'h01;
   localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_ADD_HASH = 3'd1,
      OP_OR_BYTE  = 3'd2,
      OP_MARK_ALL = 3'd3,
      OP_READ     = 3'd4,
      OP_COMPARE  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_MODIFY,
      ST_COUNT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic [7:0] diff;
   } acc_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/sud_req_if.sv
`default_nettype none

interface sud_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] hash_value;
   logic [6:0]  byte_index;
   logic [7:0]  byte_value;
   logic        other_all_true;
   logic        last_byte;

   modport source (
      output valid, req_type, hash_value, byte_index, byte_value, other_all_true, last_byte,
      input  ready
   );

   modport sink (
      input  valid, req_type, hash_value, byte_index, byte_value, other_all_true, last_byte,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/sud_rsp_if.sv
`default_nettype none

interface sud_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  read_data;
   logic [10:0] distance;
   logic        is_all_true;

   modport source (
      output valid, result_kind, read_data, distance, is_all_true,
      input  ready
   );

   modport sink (
      input  valid, result_kind, read_data, distance, is_all_true,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/signature_union_distance_top.sv
// Bit-signature store with a Hamming distance accumulator.
// Requests arrive on req_ch (valid/ready); each transaction carries one operation:
// clear, add_hash, or_byte, mark_all_true, read_byte or compare_byte. Read results
// and distance results leave on rsp_ch through an output register. The signature
// length register is written through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle; the block does not enforce it. One transaction is
// worked on at a time; ready is high only while idle. Per request: mark_all_true,
// ignored requests and out-of-range indexes stay idle; or_byte passes read and
// modify, read_byte read, modify and emit, compare_byte read, modify and a bit-serial
// popcount (one bit a cycle), and emit with last_byte; add_hash a bit-serial
// remainder of the 32-bit hash (one bit a cycle), read and modify. An out-of-range
// compare_byte with last_byte goes straight to emit. A clear sweeps the signature
// memory one byte a cycle. After reset the same sweep runs before the first
// transaction is accepted; the length register returns to 124 and the distance sum
// to zero. When the receiver stalls, a finished result waits in the output register
// and the next transaction is accepted; a later result waits until that one is taken.
`default_nettype none

module signature_union_distance_top #(
   parameter int unsigned SIG_BYTES = 128
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sud_req_if.sink     req_ch,
   sud_rsp_if.source   rsp_ch,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data
);

   localparam int unsigned AW = (SIG_BYTES > 1) ? $clog2(SIG_BYTES) : 1;
   localparam int unsigned XW = (AW > 8) ? AW : 8;
   localparam logic [7:0] LEN_CAP = (SIG_BYTES > 255) ? 8'd255 : 8'(SIG_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SIG_BYTES - 1);

   sud_pkg::state_type state_ff, state_in;

   logic [7:0]    sig_len_ff;
   logic [2:0]    op_ff;
   logic [6:0]    idx_ff;
   logic [7:0]    val_ff;
   logic          other_ff;
   logic          last_ff;
   logic          flag_ff, flag_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic [10:0]   rsp_dist_ff, rsp_dist_in;
   logic          rsp_flag_ff, rsp_flag_in;

   logic [7:0]    len;
   logic          in_range;
   logic          req_fire;
   logic          out_free;
   logic          emit_load;

   logic          div_start;
   logic          div_busy;
   logic [10:0]   div_rem;

   sud_pkg::acc_ctrl_type acc_ctrl;
   logic          acc_busy;
   logic [10:0]   acc_sum;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_addr;
   logic [XW-1:0] addr_x;
   logic [7:0]    mem_rd_data;
   logic [7:0]    mine;
   logic [7:0]    theirs;

   always_comb begin
      if (sig_len_ff == '0) begin
         len = 8'd1;
      end else if (sig_len_ff > LEN_CAP) begin
         len = LEN_CAP;
      end else begin
         len = sig_len_ff;
      end
   end

   assign in_range     = ({1'b0, req_ch.byte_index} < len);
   assign req_ch.ready = (state_ff == sud_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sud_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = sud_pkg::ST_IDLE;
            end
         end
         sud_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type) inside
                  sud_pkg::OP_CLEAR:    state_in = sud_pkg::ST_CLEAR;
                  sud_pkg::OP_ADD_HASH: state_in = sud_pkg::ST_DIV;
                  sud_pkg::OP_OR_BYTE, sud_pkg::OP_READ: begin
                     state_in = in_range ? sud_pkg::ST_READ : sud_pkg::ST_IDLE;
                  end
                  sud_pkg::OP_COMPARE: begin
                     if (in_range) begin
                        state_in = sud_pkg::ST_READ;
                     end else if (req_ch.last_byte) begin
                        state_in = sud_pkg::ST_EMIT;
                     end
                  end
                  default: state_in = sud_pkg::ST_IDLE;
               endcase
            end
         end
         sud_pkg::ST_DIV: begin
            if (!div_busy) begin
               state_in = sud_pkg::ST_READ;
            end
         end
         sud_pkg::ST_READ: state_in = sud_pkg::ST_MODIFY;
         sud_pkg::ST_MODIFY: begin
            case (op_ff)
               sud_pkg::OP_READ:    state_in = sud_pkg::ST_EMIT;
               sud_pkg::OP_COMPARE: state_in = sud_pkg::ST_COUNT;
               default:             state_in = sud_pkg::ST_IDLE;
            endcase
         end
         sud_pkg::ST_COUNT: begin
            if (!acc_busy) begin
               state_in = last_ff ? sud_pkg::ST_EMIT : sud_pkg::ST_IDLE;
            end
         end
         sud_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = sud_pkg::ST_IDLE;
            end
         end
         default: state_in = sud_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls
   always_comb begin
      div_start  = req_fire && (req_ch.req_type == sud_pkg::OP_ADD_HASH);
      emit_load  = (state_ff == sud_pkg::ST_EMIT) && out_free;

      if (op_ff == sud_pkg::OP_ADD_HASH) begin
         addr_x = XW'(div_rem[10:3]);
      end else begin
         addr_x = XW'(idx_ff);
      end
      mem_addr  = addr_x[AW-1:0];
      mem_rd_en = (state_ff == sud_pkg::ST_READ);

      mem_wr_en   = 1'b0;
      mem_wr_addr = mem_addr;
      mem_wr_data = mem_rd_data | val_ff;
      if (state_ff == sud_pkg::ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
         mem_wr_data = '0;
      end else if (state_ff == sud_pkg::ST_MODIFY) begin
         if (op_ff == sud_pkg::OP_ADD_HASH) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data | 8'(sud_pkg::BYTE_ONE << div_rem[2:0]);
         end else if (op_ff == sud_pkg::OP_OR_BYTE) begin
            mem_wr_en = 1'b1;
         end
      end

      mine          = flag_ff ? sud_pkg::BYTE_ONES : mem_rd_data;
      theirs        = other_ff ? sud_pkg::BYTE_ONES : val_ff;
      acc_ctrl.diff = mine ^ theirs;
      acc_ctrl.load = (state_ff == sud_pkg::ST_MODIFY) && (op_ff == sud_pkg::OP_COMPARE);
      acc_ctrl.clear = emit_load && (op_ff == sud_pkg::OP_COMPARE);

      clr_cnt_in = '0;
      if (state_ff == sud_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end

      flag_in = flag_ff;
      if (req_fire && (req_ch.req_type == sud_pkg::OP_CLEAR)) begin
         flag_in = 1'b0;
      end else if (req_fire && (req_ch.req_type == sud_pkg::OP_MARK_ALL)) begin
         flag_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = (op_ff == sud_pkg::OP_COMPARE);
         rsp_data_in  = rsp_kind_in ? 8'd0 : mine;
         rsp_dist_in  = rsp_kind_in ? acc_sum : 11'd0;
         rsp_flag_in  = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sud_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         flag_ff      <= 1'b0;
         sig_len_ff   <= sud_pkg::SIG_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sig_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_ch.req_type;
         idx_ff   <= req_ch.byte_index;
         val_ff   <= req_ch.byte_value;
         other_ff <= req_ch.other_all_true;
         last_ff  <= req_ch.last_byte;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   sud_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ch.hash_value),
      .divisor   ({len, 3'b000}),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   sud_dist_acc u_dist_acc (
      .clock (clock),
      .reset (reset),
      .ctrl  (acc_ctrl),
      .busy  (acc_busy),
      .sum   (acc_sum)
   );

   sud_sig_mem #(
      .DEPTH (SIG_BYTES),
      .AW    (AW)
   ) u_sig_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.distance    = rsp_dist_ff;
   assign rsp_ch.is_all_true = rsp_flag_ff;

endmodule

`default_nettype wire

// File: rtl/sud_divider.sv
`default_nettype none

module sud_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [sud_pkg::HASH_W-1:0]   dividend,
   input  wire logic [10:0]                  divisor,
   output logic                              busy,
   output logic [10:0]                       remainder
);

   logic [sud_pkg::HASH_W-1:0] dvd_ff, dvd_in;
   logic [10:0]                dvs_ff, dvs_in;
   logic [10:0]                rem_ff, rem_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic [11:0]                trial;

   always_comb begin
      trial  = {rem_ff, dvd_ff[sud_pkg::HASH_W-1]};
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = 6'(sud_pkg::HASH_W);
      end else if (cnt_ff != '0) begin
         dvd_in = {dvd_ff[sud_pkg::HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 11'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[10:0];
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/sud_dist_acc.sv
`default_nettype none

module sud_dist_acc (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sud_pkg::acc_ctrl_type       ctrl,
   output logic                             busy,
   output logic [sud_pkg::DIST_W-1:0]       sum
);

   logic [7:0]                  sh_ff, sh_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic [sud_pkg::DIST_W-1:0]  sum_ff, sum_in;

   always_comb begin
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end
      if (ctrl.load) begin
         sh_in  = ctrl.diff;
         cnt_in = 4'd8;
      end else if (cnt_ff != '0) begin
         sh_in  = {1'b0, sh_ff[7:1]};
         cnt_in = cnt_ff - 4'd1;
         if (sh_ff[0] && (sum_ff != sud_pkg::DIST_MAX)) begin
            sum_in = sum_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign busy = (cnt_ff != '0);
   assign sum  = sum_ff;

endmodule

`default_nettype wire

// File: rtl/sud_sig_mem.sv
`default_nettype none

module sud_sig_mem #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: verif/signature_distance_checker.sv
`default_nettype none

module signature_distance_checker #(
   parameter int unsigned SIG_BYTES = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   sud_req_if              req_mon,
   sud_rsp_if              rsp_mon,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   output int              failures,
   output int              outstanding
);
   import sud_pkg::*;

   localparam logic KIND_READ     = 1'b0;
   localparam logic KIND_DISTANCE = 1'b1;
   localparam int   MAX_REPORTS   = 10;

   typedef struct packed {
      logic              result_kind;
      logic [7:0]        read_data;
      logic [DIST_W-1:0] distance;
      logic              is_all_true;
   } sig_result_t;

   logic [7:0]        sig_mem [SIG_BYTES];
   logic              all_true;
   logic [DIST_W-1:0] dist_sum;
   logic [7:0]        sig_len;
   sig_result_t       pending_results [$];
   int                mismatch_total = 0;

   function automatic int unsigned active_len();
      if (sig_len == 8'd0) return 1;
      if (sig_len > SIG_BYTES) return SIG_BYTES;
      return sig_len;
   endfunction

   // Applies one transaction to the local copy of the signature state and
   // returns 1 when the transaction produces a result.
   function automatic bit predict_signature_op(
      input  logic [2:0]  op,
      input  logic [31:0] hash,
      input  logic [6:0]  idx,
      input  logic [7:0]  val,
      input  logic        other_true,
      input  logic        last,
      output sig_result_t res
   );
      int unsigned len;
      logic [31:0] bit_pos;
      logic [7:0]  mine;
      logic [7:0]  theirs;
      logic [11:0] sum;
      bit          in_range;
      len = active_len();
      in_range = idx < len;
      res = '0;
      case (op)
         OP_CLEAR: begin
            foreach (sig_mem[i]) sig_mem[i] = '0;
            all_true = 1'b0;
         end
         OP_ADD_HASH: begin
            bit_pos = hash % (len * 8);
            sig_mem[bit_pos >> 3][bit_pos[2:0]] = 1'b1;
         end
         OP_OR_BYTE: begin
            if (in_range) sig_mem[idx] = sig_mem[idx] | val;
         end
         OP_MARK_ALL: begin
            all_true = 1'b1;
         end
         OP_READ: begin
            if (in_range) begin
               res.result_kind = KIND_READ;
               res.read_data = all_true ? BYTE_ONES : sig_mem[idx];
               res.is_all_true = all_true;
               return 1'b1;
            end
         end
         OP_COMPARE: begin
            if (in_range) begin
               mine = all_true ? BYTE_ONES : sig_mem[idx];
               theirs = other_true ? BYTE_ONES : val;
               sum = dist_sum + $countones(mine ^ theirs);
               dist_sum = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
            end
            if (last) begin
               res.result_kind = KIND_DISTANCE;
               res.distance = dist_sum;
               res.is_all_true = all_true;
               dist_sum = '0;
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic check_result();
      sig_result_t seen;
      sig_result_t want;
      seen.result_kind = rsp_mon.result_kind;
      seen.read_data = rsp_mon.read_data;
      seen.distance = rsp_mon.distance;
      seen.is_all_true = rsp_mon.is_all_true;
      if (pending_results.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= MAX_REPORTS)
            $display("unexpected result: kind %0d data %02h distance %0d all_true %0d",
                     seen.result_kind, seen.read_data, seen.distance, seen.is_all_true);
      end else begin
         want = pending_results.pop_front();
         if (seen !== want) begin
            mismatch_total++;
            if (mismatch_total <= MAX_REPORTS)
               $display({"result mismatch: expected kind %0d data %02h distance %0d ",
                         "all_true %0d, got kind %0d data %02h distance %0d all_true %0d"},
                        want.result_kind, want.read_data, want.distance, want.is_all_true,
                        seen.result_kind, seen.read_data, seen.distance, seen.is_all_true);
         end
      end
   endtask

   always @(posedge clock) begin
      sig_result_t res;
      if (reset) begin
         foreach (sig_mem[i]) sig_mem[i] = '0;
         all_true = 1'b0;
         dist_sum = '0;
         sig_len = SIG_LEN_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) sig_len = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) begin
            if (predict_signature_op(req_mon.req_type, req_mon.hash_value, req_mon.byte_index,
                                     req_mon.byte_value, req_mon.other_all_true,
                                     req_mon.last_byte, res))
               pending_results.push_back(res);
         end
      end
      failures <= mismatch_total;
      outstanding <= pending_results.size();
   end

endmodule

`default_nettype wire

// File: verif/tb_signature_union_distance_top.sv
`default_nettype none

module tb_signature_union_distance_top;

   localparam int unsigned SIG_BYTES = 128;
   localparam logic [2:0]  OP_SPARE_6 = 3'd6;
   localparam logic [2:0]  OP_SPARE_7 = 3'd7;
   localparam int PHASE_ITEMS    = 95;
   localparam int SATURATION_RUN = 262;
   localparam int DRAIN_CYCLES   = 160;
   localparam int CYCLE_LIMIT    = 1000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;
   int         failures;
   int         outstanding;

   int          cur_len = 124;
   int          burst_left = 0;
   bit          steady = 1'b0;
   int          items_sent = 0;
   int          n_reads = 0;
   int          n_compares = 0;
   int          n_hashes = 0;
   int          n_settings = 0;
   int          cycles = 0;
   int          stall_count = 0;
   logic [15:0] stall_pat = '1;
   int          phase_lens [10] = '{128, 1, 0, 255, 8, 64, 200, 2, 127, 0};

   sud_req_if req_ch ();
   sud_rsp_if rsp_ch ();

   signature_union_distance_top #(
      .SIG_BYTES (SIG_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   signature_distance_checker #(
      .SIG_BYTES (SIG_BYTES)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_signature_union_distance_top: errors");
         $finish;
      end
   end

   // The receiver switches to a new stall pattern each time stall_count runs out.
   always @(posedge clock) begin
      if (stall_count == 0) begin
         stall_count <= 255;
         case ($urandom_range(0, 3))
            0: stall_pat <= '1;
            1: stall_pat <= $urandom();
            2: stall_pat <= ($urandom() & $urandom()) | 16'h0001;
            default: stall_pat <= $urandom() | $urandom();
         endcase
      end else begin
         stall_count <= stall_count - 1;
         stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      rsp_ch.ready <= stall_pat[0];
   end

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic issue(
      input logic [2:0]  op,
      input logic [31:0] hash,
      input logic [6:0]  idx,
      input logic [7:0]  val,
      input logic        other,
      input logic        last
   );
      req_ch.valid <= 1'b1;
      req_ch.req_type <= op;
      req_ch.hash_value <= hash;
      req_ch.byte_index <= idx;
      req_ch.byte_value <= val;
      req_ch.other_all_true <= other;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      case (op)
         sud_pkg::OP_READ: n_reads++;
         sud_pkg::OP_COMPARE: n_compares++;
         sud_pkg::OP_ADD_HASH: n_hashes++;
         default: ;
      endcase
      if (op <= sud_pkg::OP_COMPARE) items_sent++;
      pace();
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_len(input logic [7:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_len = (len == 8'd0) ? 1 : ((len > SIG_BYTES) ? SIG_BYTES : len);
      n_settings++;
   endtask

   function automatic logic [6:0] pick_index();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
      return $urandom_range(0, cur_len - 1);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return sud_pkg::BYTE_ONES;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic random_op();
      int          pick;
      logic [2:0]  op;
      logic [31:0] hash;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = sud_pkg::OP_CLEAR;
      else if (pick < 25) op = sud_pkg::OP_ADD_HASH;
      else if (pick < 46) op = sud_pkg::OP_OR_BYTE;
      else if (pick < 48) op = sud_pkg::OP_MARK_ALL;
      else if (pick < 70) op = sud_pkg::OP_READ;
      else if (pick < 95) op = sud_pkg::OP_COMPARE;
      else if (pick < 98) op = OP_SPARE_6;
      else op = OP_SPARE_7;
      case ($urandom_range(0, 9))
         0: hash = '0;
         1: hash = '1;
         default: hash = $urandom();
      endcase
      issue(op, hash, pick_index(), pick_byte(), $urandom_range(0, 7) == 0,
            $urandom_range(0, 3) == 0);
   endtask

   task automatic compare_run(input int count);
      for (int i = 0; i < count; i++)
         issue(sud_pkg::OP_COMPARE, $urandom(), pick_index(), pick_byte(),
               $urandom_range(0, 7) == 0, i == count - 1);
   endtask

   task automatic run_phase();
      int start;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         if ($urandom_range(0, 3) == 0) compare_run($urandom_range(1, 8));
         else random_op();
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = sud_pkg::OP_CLEAR;
      req_ch.hash_value = '0;
      req_ch.byte_index = '0;
      req_ch.byte_value = '0;
      req_ch.other_all_true = 1'b0;
      req_ch.last_byte = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_ch.ready);

      // Directed transactions at the reset length of 124 bytes.
      steady = 1'b0;
      issue(sud_pkg::OP_READ,     '0,            7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_OR_BYTE,  '0,            7'd0,   8'hff, 1'b0, 1'b0);
      issue(sud_pkg::OP_OR_BYTE,  '0,            7'd123, 8'h81, 1'b0, 1'b0);
      issue(sud_pkg::OP_OR_BYTE,  '0,            7'd124, 8'h55, 1'b0, 1'b0);
      issue(sud_pkg::OP_READ,     '0,            7'd124, 8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_READ,     '0,            7'd123, 8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_ADD_HASH, 32'h0000_0000, 7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_ADD_HASH, 32'hffff_ffff, 7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_ADD_HASH, 32'd991,       7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_READ,     '0,            7'd127, 8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd124, 8'h00, 1'b0, 1'b1);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd5,   8'h0f, 1'b0, 1'b1);
      issue(OP_SPARE_6,           '1,            '1,     '1,    1'b1, 1'b1);
      issue(OP_SPARE_7,           '1,            '1,     '1,    1'b1, 1'b1);
      issue(sud_pkg::OP_MARK_ALL, '0,            7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_READ,     '0,            7'd5,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd5,   8'h00, 1'b1, 1'b1);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd5,   8'h00, 1'b0, 1'b1);
      issue(sud_pkg::OP_ADD_HASH, 32'h8000_0000, 7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd1,   8'hf0, 1'b0, 1'b0);
      issue(sud_pkg::OP_CLEAR,    '0,            7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd1,   8'h00, 1'b0, 1'b1);
      issue(sud_pkg::OP_READ,     '0,            7'd0,   8'h00, 1'b0, 1'b0);
      issue(sud_pkg::OP_COMPARE,  '0,            7'd127, 8'hff, 1'b1, 1'b1);

      // A long compare run of a cleared signature against an all-ones other signature
      // drives the distance sum into saturation.
      settle();
      write_len(8'd128);
      steady = 1'b1;
      issue(sud_pkg::OP_CLEAR, '0, 7'd0, 8'h00, 1'b0, 1'b0);
      for (int i = 0; i < SATURATION_RUN; i++)
         issue(sud_pkg::OP_COMPARE, $urandom(), $urandom_range(0, 127),
               $urandom_range(0, 255), 1'b1, i == SATURATION_RUN - 1);

      for (int p = 0; p < 10; p++) begin
         settle();
         write_len((p == 9) ? $urandom_range(3, 126) : phase_lens[p]);
         steady = (p % 3 == 1);
         run_phase();
      end
      settle();

      $display("Summary: %0d transactions (%0d reads, %0d compares, %0d hash inserts) over %0d %s",
               items_sent, n_reads, n_compares, n_hashes, n_settings + 1,
               "signature lengths, including a saturating distance run.");
      if (failures == 0) begin
         $display("tb_signature_union_distance_top: clean");
      end else begin
         $display("tb_signature_union_distance_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: signature_union_distance_top.f
rtl/sud_pkg.sv
rtl/sud_req_if.sv
rtl/sud_rsp_if.sv
rtl/sud_divider.sv
rtl/sud_dist_acc.sv
rtl/sud_sig_mem.sv
rtl/signature_union_distance_top.sv
verif/signature_distance_checker.sv
verif/tb_signature_union_distance_top.sv
